// ===== rtl/greedy_tile_assign_exclusion_core_defines.svh =====
// Assertion macros for the tile placement core
`ifndef GREEDY_TILE_ASSIGN_EXCLUSION_CORE_DEFINES_SVH
`define GREEDY_TILE_ASSIGN_EXCLUSION_CORE_DEFINES_SVH
// implication checked on every edge outside reset
`define GTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define GTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/gta_pkg.sv =====
package gta_pkg;
  localparam int GridMax    = 64;
  localparam int TileIdBits = 16;
  localparam int MaxRadius  = 7;

  localparam logic [1:0] OutPlaced  = 2'd0;
  localparam logic [1:0] OutFilled  = 2'd1;
  localparam logic [1:0] OutNearby  = 2'd2;
  localparam logic [1:0] OutCleared = 2'd3;

  localparam logic RegGridSize = 1'b0;
  localparam logic RegRadius   = 1'b1;

  localparam logic OpClear     = 1'b0;
  localparam logic OpCandidate = 1'b1;

  typedef struct packed {
    logic        op;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic [15:0] tile_id;
    logic [31:0] match_distance;
  } req_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [5:0]  out_row;
    logic [5:0]  out_col;
    logic [15:0] out_tile;
    logic [47:0] total_cost;
  } res_t;
endpackage

// ===== rtl/gta_front.sv =====
// Front end: captures requests, decides range and window, queues them.
module gta_front #(
  parameter int GRID_MAX   = gta_pkg::GridMax,
  parameter int MAX_RADIUS = gta_pkg::MaxRadius
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  gta_pkg::req_t req_i,
  input  logic [6:0]    grid_size_i,
  input  logic [2:0]    radius_i,
  output logic          full_o,
  output logic          q_valid_o,
  output gta_pkg::req_t q_req_o,
  output logic          q_inrange_o,
  output logic [7:0]    q_r0_o,
  output logic [7:0]    q_r1_o,
  output logic [7:0]    q_c0_o,
  output logic [7:0]    q_c1_o,
  input  logic          q_pop_i
);
  import gta_pkg::*;
  localparam int Depth = 2;

  logic [8:0] g_eff, rad;
  logic [8:0] row_w, col_w, r1s, c1s;
  logic       inrange;
  logic [7:0] r0, r1, c0, c1;

  always_comb begin
    if (grid_size_i == 7'd0) g_eff = 9'd1;
    else if ({2'b0, grid_size_i} > 9'(GRID_MAX)) g_eff = 9'(GRID_MAX);
    else g_eff = {2'b0, grid_size_i};
    rad = ({6'b0, radius_i} > 9'(MAX_RADIUS)) ? 9'(MAX_RADIUS) : {6'b0, radius_i};
    row_w = {3'b0, req_i.cell_row};
    col_w = {3'b0, req_i.cell_col};
    inrange = (row_w < g_eff) && (col_w < g_eff);
    r0 = (row_w >= rad) ? 8'(row_w - rad) : 8'd0;
    c0 = (col_w >= rad) ? 8'(col_w - rad) : 8'd0;
    r1s = row_w + rad;
    c1s = col_w + rad;
    r1 = (r1s < g_eff) ? r1s[7:0] : 8'(g_eff - 9'd1);
    c1 = (c1s < g_eff) ? c1s[7:0] : 8'(g_eff - 9'd1);
  end

  typedef struct packed {
    req_t       req;
    logic       inrange;
    logic [7:0] r0, r1, c0, c1;
  } ent_t;

  ent_t       fifo_q [Depth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign push   = start_i && !full_o;
  assign full_o = (cnt_q == 2'(Depth));
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o     = fifo_q[rp_q].req;
  assign q_inrange_o = fifo_q[rp_q].inrange;
  assign q_r0_o = fifo_q[rp_q].r0;
  assign q_r1_o = fifo_q[rp_q].r1;
  assign q_c0_o = fifo_q[rp_q].c0;
  assign q_c1_o = fifo_q[rp_q].c1;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= '{req: req_i, inrange: inrange, r0: r0, r1: r1, c0: c0, c1: c1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

`include "greedy_tile_assign_exclusion_core_defines.svh"
  `GTA_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, q_pop_i, q_valid_o, "pop from empty queue")
  `GTA_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= 2'(Depth), "queue count overflow")
  `GTA_ASSERT_NXT(a_push_fills, clk_i, rst_ni, push && !q_pop_i, q_valid_o, "push lost")
endmodule

// ===== rtl/gta_back.sv =====
// Back end: scans the window over the grid memory, then commits; also runs clear sweeps.
module gta_back #(
  parameter int GRID_MAX     = gta_pkg::GridMax,
  parameter int TILE_ID_BITS = gta_pkg::TileIdBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  gta_pkg::req_t q_req_i,
  input  logic          q_inrange_i,
  input  logic [7:0]    q_r0_i,
  input  logic [7:0]    q_r1_i,
  input  logic [7:0]    q_c0_i,
  input  logic [7:0]    q_c1_i,
  output logic          q_pop_o,
  output logic          idle_o,
  output logic          res_valid_o,
  output gta_pkg::res_t res_o
);
  import gta_pkg::*;
  localparam int Cells = GRID_MAX * GRID_MAX;
  localparam int AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int NCW   = $clog2(Cells + 1);
  localparam logic [47:0] CostMax = '1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,
    S_SELF  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_CHECK = 5'b10000
  } state_e;

  state_e state_q, state_d;
  // tile and filled bit live in one memory word; a clear sweeps filled bits
  logic [TILE_ID_BITS:0] mem [Cells];
  logic [TILE_ID_BITS:0] rd_q;
  logic [AW-1:0]  raddr, waddr;
  logic           we;
  logic [TILE_ID_BITS:0] wdata;
  logic [NCW-1:0] clr_q, clr_d;
  logic [7:0]     r_q, r_d, c_q, c_d;
  logic           rdv_q, rdv_d, last_q, last_d, hit_q, hit_d;
  // set out of reset: the first sweep empties the grid and gives no result
  logic           boot_q, boot_d;
  logic [47:0]    cost_q, cost_d;
  logic [48:0]    sum;
  logic [TILE_ID_BITS-1:0] tile;
  logic [AW-1:0]  self_a;
  logic           pop;

  assign tile   = TILE_ID_BITS'(q_req_i.tile_id);
  assign self_a = AW'(q_req_i.cell_row) * AW'(GRID_MAX) + AW'(q_req_i.cell_col);
  assign raddr  = AW'(r_q) * AW'(GRID_MAX) + AW'(c_q);
  assign sum    = {1'b0, cost_q} + {17'b0, q_req_i.match_distance};
  assign q_pop_o = pop;
  assign idle_o  = (state_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[(state_q == S_SELF) ? self_a : raddr];
  end

  always_comb begin
    state_d = state_q; clr_d = clr_q; r_d = r_q; c_d = c_q;
    rdv_d = 1'b0; last_d = last_q; hit_d = hit_q; cost_d = cost_q; boot_d = boot_q;
    we = 1'b0; waddr = self_a; wdata = {1'b1, tile};
    pop = 1'b0; res_valid_o = 1'b0;
    res_o = '{outcome: OutFilled, out_row: q_req_i.cell_row, out_col: q_req_i.cell_col,
              out_tile: 16'(tile), total_cost: cost_q};
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          if (q_req_i.op == OpClear) begin
            state_d = S_CLEAR; clr_d = '0;
          end else if (!q_inrange_i) begin
            pop = 1'b1; res_valid_o = 1'b1;
          end else begin
            state_d = S_SELF;
          end
        end
      end
      S_CLEAR: begin
        we = 1'b1; waddr = AW'(clr_q); wdata = '0;
        clr_d = clr_q + NCW'(1);
        if (clr_q == NCW'(Cells - 1)) begin
          state_d = S_IDLE; boot_d = 1'b0;
          if (!boot_q) begin
            pop = 1'b1; res_valid_o = 1'b1; cost_d = '0;
            res_o = '{outcome: OutCleared, out_row: '0, out_col: '0, out_tile: '0,
                      total_cost: '0};
          end
        end
      end
      S_SELF: begin
        state_d = S_SCAN; r_d = q_r0_i; c_d = q_c0_i; rdv_d = 1'b0; hit_d = 1'b0;
        last_d = 1'b0;
      end
      S_SCAN: begin
        if (rdv_q && rd_q[TILE_ID_BITS] && rd_q[TILE_ID_BITS-1:0] == tile) hit_d = 1'b1;
        if (!rdv_q && !last_q && r_q == q_r0_i && c_q == q_c0_i && hit_q == 1'b0
            && rd_q[TILE_ID_BITS]) begin
          // own cell was filled: first read of this state is the self read
          state_d = S_IDLE; pop = 1'b1; res_valid_o = 1'b1;
        end else if (last_q) begin
          state_d = S_CHECK;
        end else begin
          rdv_d = 1'b1;
          if (c_q == q_c1_i) begin
            c_d = q_c0_i;
            if (r_q == q_r1_i) last_d = 1'b1; else r_d = r_q + 8'd1;
          end else c_d = c_q + 8'd1;
        end
      end
      S_CHECK: begin
        state_d = S_IDLE; pop = 1'b1; res_valid_o = 1'b1;
        if (hit_q) res_o.outcome = OutNearby;
        else begin
          we = 1'b1;
          cost_d = sum[48] ? CostMax : sum[47:0];
          res_o.outcome = OutPlaced; res_o.total_cost = cost_d;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; r_q <= '0; c_q <= '0; boot_q <= 1'b1;
      rdv_q <= 1'b0; last_q <= 1'b0; hit_q <= 1'b0; cost_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; r_q <= r_d; c_q <= c_d; boot_q <= boot_d;
      rdv_q <= rdv_d; last_q <= last_d; hit_q <= hit_d; cost_q <= cost_d;
    end
  end

`include "greedy_tile_assign_exclusion_core_defines.svh"
  `GTA_ASSERT_IMP(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q), "state not one-hot")
  `GTA_ASSERT_IMP(a_pop_res, clk_i, rst_ni, pop, res_valid_o, "pop without result")
  `GTA_ASSERT_IMP(a_res_pop, clk_i, rst_ni, res_valid_o, pop, "result without pop")
  `GTA_ASSERT_NXT(a_cost_mono, clk_i, rst_ni, state_q != S_CLEAR, cost_q >= $past(cost_q),
                  "cost decreased")
endmodule

// ===== rtl/greedy_tile_assign_exclusion_core.sv =====
// Greedy mosaic tile placement core.
// Request channel: start_i with req_i; taken at an edge where start_i is high
// and busy_o is low. op clear empties the grid and zeroes the total cost,
// op candidate offers one tile for one cell (candidates sorted by distance).
// Result channel: res_valid_o strobes for one cycle with res_o; the receiver
// cannot stall, so results are never held back.
// Config channel: cfg_valid_i/cfg_ready_o with register index and data;
// index 0 grid size, index 1 exclusion radius. Write only while idle.
// A two-entry queue parts the front (range and window decode) from the back
// (window scan over a grid memory with one read and one write port, one cell
// per cycle). An out-of-range candidate is answered from idle; a candidate
// on a filled own cell after the self read; any other after the window scan
// and a check step. A clear sweeps every grid word (GRID_MAX*GRID_MAX, 4096
// by default), then gives its result. Results leave through an output
// register. The back end finishes one request before it takes the next.
// Reset clears control, cost and queue, then sweeps the grid empty (no
// result); up to two requests queue meanwhile. Registers reset to 64 and 2.
module greedy_tile_assign_exclusion_core #(
  parameter int GRID_MAX     = gta_pkg::GridMax,
  parameter int TILE_ID_BITS = gta_pkg::TileIdBits,
  parameter int MAX_RADIUS   = gta_pkg::MaxRadius
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  gta_pkg::req_t req_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output gta_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [6:0]    cfg_data_i
);
  import gta_pkg::*;

  logic [6:0] grid_q;
  logic [2:0] rad_q;
  logic       q_valid, q_inrange, q_pop, idle, full;
  req_t       q_req;
  logic [7:0] r0, r1, c0, c1;
  res_t       res_d, res_q;
  logic       rv_d, rv_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = full;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= 7'd64; rad_q <= 3'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegGridSize: grid_q <= cfg_data_i;
        RegRadius:   rad_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  gta_front #(.GRID_MAX(GRID_MAX), .MAX_RADIUS(MAX_RADIUS)) u_front (
    .clk_i, .rst_ni, .start_i, .req_i,
    .grid_size_i(grid_q), .radius_i(rad_q), .full_o(full),
    .q_valid_o(q_valid), .q_req_o(q_req), .q_inrange_o(q_inrange),
    .q_r0_o(r0), .q_r1_o(r1), .q_c0_o(c0), .q_c1_o(c1), .q_pop_i(q_pop)
  );

  gta_back #(.GRID_MAX(GRID_MAX), .TILE_ID_BITS(TILE_ID_BITS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_req_i(q_req), .q_inrange_i(q_inrange),
    .q_r0_i(r0), .q_r1_i(r1), .q_c0_i(c0), .q_c1_i(c1),
    .q_pop_o(q_pop), .idle_o(idle), .res_valid_o(rv_d), .res_o(res_d)
  );

  // Output register
  always_ff @(posedge clk_i) res_q <= res_d;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= 1'b0;
    else rv_q <= rv_d;
  end
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

`include "greedy_tile_assign_exclusion_core_defines.svh"
  `GTA_ASSERT_IMP(a_pop_valid, clk_i, rst_ni, q_pop, q_valid, "back popped empty queue")
  `GTA_ASSERT_NXT(a_strobe, clk_i, rst_ni, rv_d, res_valid_o, "result strobe lost")
  `GTA_ASSERT_IMP(a_idle_nopop, clk_i, rst_ni, idle && !q_valid, !q_pop, "spurious pop")
endmodule

// ===== sim/greedy_tile_assign_exclusion_core_tb.sv =====
module greedy_tile_assign_exclusion_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gta_pkg::*;

  // Cycles without any handshake before the run is abandoned.
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned Cells      = GridMax * GridMax;

  // Placement tracker: own copy of the grid, the running cost and the two
  // registers; keeps the outcomes still owed by the core in arrival order.
  class placement_tracker;
    bit [15:0]   tile_at[Cells];
    bit          filled[Cells];
    logic [47:0] cost;
    logic [6:0]  grid_reg;
    logic [2:0]  radius_reg;
    res_t        owed[$];
    int unsigned mismatches;

    function new();
      foreach (filled[i]) begin
        filled[i]  = 1'b0;
        tile_at[i] = '0;
      end
      cost       = '0;
      grid_reg   = 7'd64;
      radius_reg = 3'd2;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [6:0] data);
      if (idx == RegGridSize) grid_reg = data;
      else radius_reg = data[2:0];
    endfunction

    function int unsigned grid_cells();
      if (grid_reg == 0) return 1;
      if (grid_reg > GridMax) return GridMax;
      return grid_reg;
    endfunction

    function bit same_tile_near(int unsigned row, int unsigned col, int unsigned g,
                                bit [15:0] tile);
      int unsigned rad;
      int unsigned r0, r1, c0, c1;
      rad = (radius_reg > MaxRadius) ? MaxRadius : radius_reg;
      r0  = (row >= rad) ? row - rad : 0;
      c0  = (col >= rad) ? col - rad : 0;
      r1  = (row + rad < g) ? row + rad : g - 1;
      c1  = (col + rad < g) ? col + rad : g - 1;
      for (int unsigned r = r0; r <= r1; r++)
        for (int unsigned c = c0; c <= c1; c++)
          if (filled[r * GridMax + c] && tile_at[r * GridMax + c] == tile) return 1'b1;
      return 1'b0;
    endfunction

    // Work out what the core must answer to an accepted request.
    function void note_request(req_t rq);
      res_t        exp;
      int unsigned g, a;
      logic [48:0] sum;
      if (rq.op == OpClear) begin
        foreach (filled[i]) filled[i] = 1'b0;
        cost = '0;
        exp  = '0;
        exp.outcome = OutCleared;
      end else begin
        g = grid_cells();
        exp.out_row  = rq.cell_row;
        exp.out_col  = rq.cell_col;
        exp.out_tile = rq.tile_id;
        a = rq.cell_row * GridMax + rq.cell_col;
        if (rq.cell_row >= g || rq.cell_col >= g || filled[a]) begin
          exp.outcome = OutFilled;
        end else if (same_tile_near(rq.cell_row, rq.cell_col, g, rq.tile_id)) begin
          exp.outcome = OutNearby;
        end else begin
          exp.outcome = OutPlaced;
          tile_at[a]  = rq.tile_id;
          filled[a]   = 1'b1;
          sum  = {1'b0, cost} + {17'd0, rq.match_distance};
          cost = sum[48] ? '1 : sum[47:0];
        end
        exp.total_cost = cost;
      end
      owed.push_back(exp);
    endfunction

    function void check_result(res_t act);
      res_t exp;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", act);
        return;
      end
      exp = owed.pop_front();
      if (act.outcome !== exp.outcome || act.out_row !== exp.out_row ||
          act.out_col !== exp.out_col || act.out_tile !== exp.out_tile ||
          act.total_cost !== exp.total_cost) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp, act);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  req_t       req_i;
  logic       busy_o;
  logic       res_valid_o;
  res_t       res_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_index_i;
  logic [6:0] cfg_data_i;

  placement_tracker tracker = new();
  int unsigned      quiet_cycles;
  bit               no_gaps;

  greedy_tile_assign_exclusion_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Results cannot be held off: every strobe is checked on the edge it ends.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) tracker.check_result(res_o);
  end

  // Watchdog on handshake activity of any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || res_valid_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly short gaps, the odd long one, none at all in no-gap stretches.
  task automatic sender_gap();
    int unsigned n;
    n = no_gaps ? 0 :
        ($urandom_range(0, 9) == 0) ? $urandom_range(15, 80) : $urandom_range(0, 2);
    if (n != 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Present one request and hold it until the core takes it.
  task automatic send_request(req_t rq);
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= rq;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    tracker.note_request(rq);
    sender_gap();
  endtask

  task automatic send_clear();
    req_t rq;
    rq    = req_t'($bits(req_t)'({$urandom, $urandom})); // fields other than op are don't-care
    rq.op = OpClear;
    send_request(rq);
  endtask

  task automatic send_candidate(int unsigned row, int unsigned col, int unsigned tile,
                                logic [31:0] match_dist);
    req_t rq;
    rq.op             = OpCandidate;
    rq.cell_row       = row[5:0];
    rq.cell_col       = col[5:0];
    rq.tile_id        = tile[15:0];
    rq.match_distance = match_dist;
    send_request(rq);
  endtask

  // Wait for every owed result, then a short settle before touching registers.
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [6:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    tracker.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random candidate, aimed mostly at a small patch so that cells clash
  // and tiles repeat; a few land anywhere, out of the grid included.
  task automatic random_candidate();
    int unsigned g, span, row, col, tile;
    logic [31:0] match_dist;
    g    = tracker.grid_cells();
    span = (g > 10) ? 10 : g;
    if ($urandom_range(0, 9) == 0) begin
      row = $urandom_range(0, 63);
      col = $urandom_range(0, 63);
    end else begin
      row = $urandom_range(0, span);
      col = $urandom_range(0, span);
    end
    case ($urandom_range(0, 5))
      0:       tile = $urandom_range(0, 65535);
      1:       tile = 16'hFFF0 | $urandom_range(0, 3);
      default: tile = $urandom_range(0, 3);
    endcase
    case ($urandom_range(0, 7))
      0:       match_dist = '0;
      1:       match_dist = '1;
      default: match_dist = $urandom;
    endcase
    send_candidate(row, col, tile, match_dist);
  endtask

  // Register settings per phase (grid size, radius), extremes included;
  // grid 0 folds to one cell, grid above 64 saturates.
  int unsigned grid_set[11]   = '{64, 1, 8, 64, 5, 0, 127, 16, 3, 100, 64};
  int unsigned radius_set[11] = '{2, 0, 1, 7, 3, 4, 7, 2, 5, 0, 6};

  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_i        = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = RegGridSize;
    cfg_data_i   = '0;
    no_gaps      = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset settings (grid 64, radius 2), opening with a
    // clear on an already empty grid.
    send_clear();
    send_candidate(0, 0, 5, 32'hFFFF_FFFF);   // placed, max distance
    send_candidate(0, 0, 6, 1);               // own cell filled
    send_candidate(1, 1, 5, 1);               // same tile next door
    send_candidate(2, 2, 5, 1);               // same tile at window edge
    send_candidate(3, 3, 5, 0);               // just outside the window
    send_candidate(63, 63, 16'hFFFF, 32'h8000_0000); // far corner, all-ones tile
    send_candidate(63, 62, 16'hFFFF, 7);      // clipped window, repeat refused
    send_candidate(61, 61, 16'hFFFF, 7);      // radius 2 reaches corner
    send_candidate(10, 20, 0, 32'hFFFF_FFFF); // tile zero
    send_candidate(10, 21, 1, 32'hFFFF_FFFF);
    drain();
    write_reg(RegGridSize, 7'd8);
    write_reg(RegRadius, 3'd0);
    send_candidate(8, 0, 2, 3);               // row just outside the grid
    send_candidate(0, 8, 2, 3);               // column just outside
    send_candidate(63, 63, 2, 3);
    send_candidate(7, 7, 2, 3);               // radius 0: only own cell
    send_candidate(7, 6, 2, 3);               // same tile adjacent is allowed
    send_clear();
    send_candidate(7, 7, 2, 3);               // cell free again after clear
    drain();

    // Random phases.
    foreach (grid_set[p]) begin
      write_reg(RegGridSize, grid_set[p][6:0]);
      write_reg(RegRadius, radius_set[p][2:0]);
      no_gaps = (p % 3 == 1);
      send_clear();
      repeat (55) begin
        if ($urandom_range(0, 79) == 0) send_clear();
        else random_candidate();
      end
      // Sender holds off until every owed result is in.
      drain();
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.owed.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
